// ===== rtl/mea_pkg.sv =====
// ----------------------------------------------------------------------------
// mea_pkg
// Shared types, constants and operation codes for the monomial exponent ALU.
// ----------------------------------------------------------------------------
package mea_pkg;

   localparam int NUM_VARS     = 8;
   localparam int EXP_WIDTH    = 8;
   localparam int DATA_WIDTH   = 64;
   localparam int VEC_WIDTH    = NUM_VARS * EXP_WIDTH;
   localparam int PAD_WIDTH    = (VEC_WIDTH > DATA_WIDTH) ? VEC_WIDTH : DATA_WIDTH;
   localparam int OP_WIDTH     = 4;
   localparam int SEL_WIDTH    = 3;
   localparam int SCALAR_WIDTH = 11;
   localparam int SUM_WIDTH    = EXP_WIDTH + $clog2(NUM_VARS + 1);

   localparam logic [SCALAR_WIDTH-1:0] SCALAR_MAX = {SCALAR_WIDTH{1'b1}};

   // Request tdata layout: left, right, var_index, zero fill to whole bytes.
   localparam int REQ_LEFT_LSB  = 0;
   localparam int REQ_RIGHT_LSB = REQ_LEFT_LSB + DATA_WIDTH;
   localparam int REQ_SEL_LSB   = REQ_RIGHT_LSB + DATA_WIDTH;
   localparam int REQ_BITS      = REQ_SEL_LSB + SEL_WIDTH;
   localparam int REQ_TDATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // Response tdata layout: result, test_flag, scalar, overflow, div_error.
   localparam int RSP_BITS      = DATA_WIDTH + 1 + SCALAR_WIDTH + 1 + 1;
   localparam int RSP_TDATA_W   = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_MUL       = 4'd0,
      OP_DIV       = 4'd1,
      OP_GCD       = 4'd2,
      OP_LCM       = 4'd3,
      OP_DIVISIBLE = 4'd4,
      OP_EQUAL     = 4'd5,
      OP_DEGREE    = 4'd6,
      OP_LAST_VAR  = 4'd7,
      OP_VAR_EXP   = 4'd8
   } op_type;

   typedef logic [EXP_WIDTH-1:0] exp_type;
   typedef exp_type [NUM_VARS-1:0] exp_vec_type;

   typedef struct packed {
      exp_type res;
      logic    sat;
      logic    borrow;
      logic    ne;
   } lane_out_type;

   typedef lane_out_type [NUM_VARS-1:0] lane_vec_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0]   exps;
      logic                    flag;
      logic [SCALAR_WIDTH-1:0] scalar;
      logic                    ovf;
      logic                    derr;
   } result_type;

endpackage

// ===== rtl/monomial_exponent_alu.sv =====
// ----------------------------------------------------------------------------
// monomial_exponent_alu
// Lane-parallel ALU over packed monomial exponent vectors.
// ----------------------------------------------------------------------------
// A new request is taken every cycle unless the pipeline stalls, and its response
// passes through the register stages in turn: the first holds the per-variable lane
// results, the second holds the merged response. The sustained rate is one
// request per cycle; the pipeline only stalls when the response side holds
// tready low, and then fills both stages before it deasserts req_tready.
// ----------------------------------------------------------------------------
module monomial_exponent_alu
   import mea_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: left_exponents[63:0], right_exponents[127:64], var_index[130:128], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: req_type[3:0]
   input  logic [OP_WIDTH-1:0]    req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: result_exponents[63:0], test_flag[64], scalar_value[75:65],
   //        overflow[76], div_error[77], zero fill
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [PAD_WIDTH-1:0]  left_pad;
   logic [PAD_WIDTH-1:0]  right_pad;
   exp_vec_type           left_vec;
   exp_vec_type           right_vec;
   lane_vec_type          lane_vec;

   logic                  s1_valid_ff, s1_valid_in;
   lane_vec_type          s1_lanes_ff;
   exp_vec_type           s1_xs_ff;
   logic [OP_WIDTH-1:0]   s1_op_ff;
   logic [SEL_WIDTH-1:0]  s1_sel_ff;
   logic                  s1_en;

   result_type            merged;
   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff;
   logic                  out_en;

   // Lanes that run past the data width read zeros there.
   assign left_pad  = PAD_WIDTH'(req_tdata[REQ_LEFT_LSB +: DATA_WIDTH]);
   assign right_pad = PAD_WIDTH'(req_tdata[REQ_RIGHT_LSB +: DATA_WIDTH]);
   assign left_vec  = left_pad[VEC_WIDTH-1:0];
   assign right_vec = right_pad[VEC_WIDTH-1:0];

   for (genvar g = 0; g < NUM_VARS; g++) begin : g_lane
      mea_lane u_lane (
         .op       (req_tuser),
         .x        (left_vec[g]),
         .y        (right_vec[g]),
         .lane_out (lane_vec[g])
      );
   end

   assign out_en       = ~out_valid_ff | rsp_tready;
   assign s1_en        = ~s1_valid_ff | out_en;
   assign req_tready   = s1_en;
   assign s1_valid_in  = s1_en ? req_tvalid : s1_valid_ff;
   assign out_valid_in = out_en ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_lanes_ff <= lane_vec;
         s1_xs_ff    <= left_vec;
         s1_op_ff    <= req_tuser;
         s1_sel_ff   <= req_tdata[REQ_SEL_LSB +: SEL_WIDTH];
      end
   end

   mea_merge u_merge (
      .op     (s1_op_ff),
      .sel    (s1_sel_ff),
      .lanes  (s1_lanes_ff),
      .xs     (s1_xs_ff),
      .result (merged)
   );

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_ff <= merged;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_ff.derr, out_ff.ovf, out_ff.scalar,
                                     out_ff.flag, out_ff.exps});

endmodule

// ===== rtl/mea_lane.sv =====
// ----------------------------------------------------------------------------
// mea_lane
// One exponent lane: saturating add, subtract, min and max, plus the
// per-lane compare bits that the merge stage reduces.
// ----------------------------------------------------------------------------
module mea_lane
   import mea_pkg::*;
(
   input  logic [OP_WIDTH-1:0] op,
   input  exp_type             x,
   input  exp_type             y,
   output lane_out_type        lane_out
);

   logic [EXP_WIDTH:0] sum;
   logic               borrow;
   exp_type            diff;
   exp_type            min_val;
   exp_type            max_val;

   assign sum     = {1'b0, x} + {1'b0, y};
   assign borrow  = (y > x);
   assign diff    = x - y;
   assign min_val = borrow ? x : y;
   assign max_val = borrow ? y : x;

   always_comb begin
      lane_out.sat    = sum[EXP_WIDTH];
      lane_out.borrow = borrow;
      lane_out.ne     = (x != y);
      case (op)
         OP_MUL:  lane_out.res = sum[EXP_WIDTH] ? {EXP_WIDTH{1'b1}} : sum[EXP_WIDTH-1:0];
         OP_DIV:  lane_out.res = diff;
         OP_GCD:  lane_out.res = min_val;
         OP_LCM:  lane_out.res = max_val;
         default: lane_out.res = '0;
      endcase
   end

endmodule

// ===== rtl/mea_merge.sv =====
// ----------------------------------------------------------------------------
// mea_merge
// Combines the registered lane outputs into one response: packs the vector,
// reduces the flags, totals the degree and locates variables.
// ----------------------------------------------------------------------------
module mea_merge
   import mea_pkg::*;
(
   input  logic [OP_WIDTH-1:0]  op,
   input  logic [SEL_WIDTH-1:0] sel,
   input  lane_vec_type         lanes,
   input  exp_vec_type          xs,
   output result_type           result
);

   exp_vec_type            res_vec;
   logic [PAD_WIDTH-1:0]   res_pad;
   logic                   any_sat;
   logic                   any_borrow;
   logic                   any_ne;
   logic [SUM_WIDTH-1:0]   degree;
   logic [SCALAR_WIDTH-1:0] last_var;
   exp_type                sel_exp;

   always_comb begin
      any_sat    = 1'b0;
      any_borrow = 1'b0;
      any_ne     = 1'b0;
      degree     = '0;
      last_var   = '0;
      sel_exp    = '0;
      for (int i = 0; i < NUM_VARS; i++) begin
         res_vec[i] = lanes[i].res;
         any_sat    = any_sat | lanes[i].sat;
         any_borrow = any_borrow | lanes[i].borrow;
         any_ne     = any_ne | lanes[i].ne;
         degree     = degree + SUM_WIDTH'(xs[i]);
         if (xs[i] != '0) begin
            last_var = SCALAR_WIDTH'(i);
         end
         if (int'(sel) == i) begin
            sel_exp = xs[i];
         end
      end
   end

   assign res_pad = PAD_WIDTH'(res_vec);

   always_comb begin
      result = '0;
      case (op)
         OP_MUL: begin
            result.exps = res_pad[DATA_WIDTH-1:0];
            result.ovf  = any_sat;
         end
         OP_DIV: begin
            // An inexact divide returns an all-zero vector.
            result.exps = any_borrow ? '0 : res_pad[DATA_WIDTH-1:0];
            result.derr = any_borrow;
         end
         OP_GCD, OP_LCM: begin
            result.exps = res_pad[DATA_WIDTH-1:0];
         end
         OP_DIVISIBLE: begin
            result.flag = ~any_borrow;
         end
         OP_EQUAL: begin
            result.flag = ~any_ne;
         end
         OP_DEGREE: begin
            result.scalar = (degree > SUM_WIDTH'(SCALAR_MAX)) ? SCALAR_MAX
                                                               : SCALAR_WIDTH'(degree);
         end
         OP_LAST_VAR: begin
            result.scalar = last_var;
         end
         OP_VAR_EXP: begin
            result.scalar = SCALAR_WIDTH'(sel_exp);
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule
